[src/mihd_pkg.sv]
package mihd_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DILATE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_PASS_COUNT   = 2'd0,
    CFG_FILL_VALUE   = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PX,
    S_MUL,
    S_WR,
    S_CNT,
    S_CNT_TAIL
  } state_t;

  // Neighbour taps, in the order in which they are read for one pixel.
  typedef enum logic [2:0] {
    TAP_CENTER = 3'd0,
    TAP_RIGHT  = 3'd1,
    TAP_LEFT   = 3'd2,
    TAP_DOWN   = 3'd3,
    TAP_UP     = 3'd4,
    TAP_DONE   = 3'd5
  } tap_t;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned WORD_W  = VALUE_W + 1;
  localparam int unsigned SUM_W   = VALUE_W + 2;
  localparam int unsigned COUNT_W = 17;
  // ceil(2^20 / 3): exact division by three for every sum below 2^19.
  localparam logic [18:0] RECIP3  = 19'd349526;
  localparam int unsigned PROD_W  = SUM_W + 19;

  localparam logic [7:0]  PASS_COUNT_RST = 8'd16;
  localparam logic [15:0] FILL_VALUE_RST = 16'd0;
  localparam logic [8:0]  IMAGE_SIZE_RST = 9'd256;

endpackage

[src/masked_image_hole_dilation.sv]
// Masked image hole dilation. The image is held in two banks of on-chip RAM used
// as ping-pong buffers: a pass reads the current bank and writes the other, then the
// banks swap. When the pass count is odd, one extra copy pass follows, so that the
// image always ends up back in the first bank. Write transactions stream back to back
// while the output is not stalled; a read holds off the input while the RAM output is
// registered. A dilate transaction visits every pixel of the image in use once per pass,
// with five neighbour reads through the single RAM read port, one multiply and one
// write-back per pixel, and then scans the image once more at one pixel a cycle to
// count invalid pixels. Result transactions always carry all three output fields;
// fields not used by the op are zero.
module masked_image_hole_dilation
  import mihd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [7:0]           pixel_x,
  input  logic [7:0]           pixel_y,
  input  logic [15:0]          pixel_value,
  input  logic                 pixel_valid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          read_value,
  output logic                 read_valid,
  output logic [COUNT_W-1:0]   still_invalid
);

  localparam int unsigned XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 1 << AW;

  logic [WORD_W-1:0] bank0 [DEPTH];
  logic [WORD_W-1:0] bank1 [DEPTH];
  logic [WORD_W-1:0] q0, q1, rdata;

  logic [7:0]  pass_count;
  logic [15:0] fill_value;
  logic [8:0]  image_width;
  logic [8:0]  image_height;

  state_t state, state_next;
  logic             cur;
  logic [8:0]       pass_left;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [2:0]       k;
  logic [WORD_W-1:0] center;
  logic [SUM_W-1:0] sum;
  logic [2:0]       cnt;
  logic [PROD_W-1:0] prod;
  logic             cnt_pend;
  logic [COUNT_W-1:0] count;
  logic             rd_in_area;

  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic [31:0]   px32, py32;
  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic          in_area;
  logic          accept, out_free, last_px, copy_now, out_load;
  logic [AW-1:0] raddr, waddr;
  logic          we, wbank;
  logic [WORD_W-1:0] wdata;
  logic [15:0]   quot;

  // Effective image size, saturated to 1..MAX.
  always_comb begin
    if (image_width == 9'd0) begin
      w_last = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(32'(image_width) - 32'd1);
    end
    if (image_height == 9'd0) begin
      h_last = '0;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_last = YW'(MAX_HEIGHT - 1);
    end else begin
      h_last = YW'(32'(image_height) - 32'd1);
    end
  end

  assign px32    = {24'd0, pixel_x};
  assign py32    = {24'd0, pixel_y};
  assign in_x    = px32[XW-1:0];
  assign in_y    = py32[YW-1:0];
  assign in_area = (px32 <= 32'(w_last)) && (py32 <= 32'(h_last));

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign last_px  = (x == w_last) && (y == h_last);
  // The final pass of an odd pass count only copies the image back.
  assign copy_now = pass_count[0] && (pass_left == 9'd1);
  assign out_load = ((state == S_IDLE) && accept && (op == OP_WRITE || op == OP_NONE)) ||
                    (state == S_RD) || (state == S_CNT_TAIL);

  function automatic logic tap_en(input logic [2:0] t, input logic [XW-1:0] tx,
                                  input logic [YW-1:0] ty, input logic [XW-1:0] wl,
                                  input logic [YW-1:0] hl);
    logic r;
    case (t)
      TAP_RIGHT: r = tx < wl;
      TAP_LEFT:  r = tx != '0;
      TAP_DOWN:  r = ty < hl;
      TAP_UP:    r = ty != '0;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  // Read address.
  always_comb begin
    raddr = {y, x};
    case (state)
      S_IDLE: raddr = {in_y, in_x};
      S_PX: begin
        if (tap_en(k, x, y, w_last, h_last)) begin
          case (k)
            TAP_RIGHT: raddr = {y, x + XW'(1)};
            TAP_LEFT:  raddr = {y, x - XW'(1)};
            TAP_DOWN:  raddr = {y + YW'(1), x};
            TAP_UP:    raddr = {y - YW'(1), x};
            default:   raddr = {y, x};
          endcase
        end
      end
      default: raddr = {y, x};
    endcase
  end

  always_comb begin
    case (cnt)
      3'd1:    quot = sum[15:0];
      3'd2:    quot = sum[16:1];
      3'd3:    quot = prod[35:20];
      3'd4:    quot = sum[17:2];
      default: quot = center[15:0];
    endcase
  end

  // Write port.
  always_comb begin
    we    = 1'b0;
    wbank = cur;
    waddr = {in_y, in_x};
    wdata = {pixel_valid, pixel_value};
    if (state == S_IDLE) begin
      we = accept && (op == OP_WRITE) && in_area;
    end else if (state == S_WR) begin
      we    = 1'b1;
      wbank = !cur;
      waddr = {y, x};
      if (copy_now || center[VALUE_W] || cnt == 3'd0) begin
        wdata = center;
      end else begin
        wdata = {1'b1, quot};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      bank0[waddr] <= wdata;
    end
    q0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we && wbank) begin
      bank1[waddr] <= wdata;
    end
    q1 <= bank1[raddr];
  end

  assign rdata = cur ? q1 : q0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_READ) begin
          state_next = S_RD;
        end else if (accept && op == OP_DILATE) begin
          state_next = (pass_count == 8'd0) ? S_CNT : S_PX;
        end
      end
      S_RD:    state_next = S_IDLE;
      S_PX:    state_next = (k == TAP_DONE) ? S_MUL : S_PX;
      S_MUL:   state_next = S_WR;
      S_WR: begin
        if (last_px) begin
          state_next = (pass_left == 9'd1) ? S_CNT : S_PX;
        end else begin
          state_next = S_PX;
        end
      end
      S_CNT:      state_next = last_px ? S_CNT_TAIL : S_CNT;
      S_CNT_TAIL: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count   <= PASS_COUNT_RST;
      fill_value   <= FILL_VALUE_RST;
      image_width  <= IMAGE_SIZE_RST;
      image_height <= IMAGE_SIZE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PASS_COUNT:   pass_count   <= cfg_data[7:0];
        CFG_FILL_VALUE:   fill_value   <= cfg_data;
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= 1'b0;
      out_valid <= 1'b0;
      cnt_pend  <= 1'b0;
      k         <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          x <= '0;
          y <= '0;
          k <= '0;
          cnt_pend   <= 1'b0;
          count      <= '0;
          rd_in_area <= in_area;
          pass_left  <= {1'b0, pass_count} + {8'd0, pass_count[0]};
          if (accept && (op == OP_WRITE || op == OP_NONE)) begin
            read_value    <= '0;
            read_valid    <= 1'b0;
            still_invalid <= '0;
          end
        end
        S_RD: begin
          still_invalid <= '0;
          if (rd_in_area && rdata[VALUE_W]) begin
            read_value <= rdata[15:0];
            read_valid <= 1'b1;
          end else begin
            read_value <= fill_value;
            read_valid <= 1'b0;
          end
        end
        S_PX: begin
          k <= k + 3'd1;
          if (k == TAP_CENTER) begin
            sum <= '0;
            cnt <= '0;
          end else if (k - 3'd1 == TAP_CENTER) begin
            center <= rdata;
          end else if (tap_en(k - 3'd1, x, y, w_last, h_last) && rdata[VALUE_W]) begin
            sum <= sum + SUM_W'(rdata[15:0]);
            cnt <= cnt + 3'd1;
          end
        end
        S_MUL: begin
          prod <= PROD_W'(sum) * PROD_W'(RECIP3);
        end
        S_WR: begin
          k <= '0;
          if (x == w_last) begin
            x <= '0;
            y <= (y == h_last) ? '0 : y + YW'(1);
          end else begin
            x <= x + XW'(1);
          end
          if (last_px) begin
            cur       <= !cur;
            pass_left <= pass_left - 9'd1;
          end
        end
        S_CNT: begin
          cnt_pend <= 1'b1;
          if (cnt_pend && !rdata[VALUE_W] && count != '1) begin
            count <= count + COUNT_W'(1);
          end
          if (x == w_last) begin
            x <= '0;
            y <= y + YW'(1);
          end else begin
            x <= x + XW'(1);
          end
        end
        S_CNT_TAIL: begin
          read_value <= '0;
          read_valid <= 1'b0;
          if (!rdata[VALUE_W] && count != '1) begin
            still_invalid <= count + COUNT_W'(1);
          end else begin
            still_invalid <= count;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[src/mihd_checker.sv]
module mihd_checker
  import mihd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  op,
  input logic        out_valid,
  input logic        out_stall,
  input logic        read_valid,
  input logic [16:0] still_invalid
);

  logic accept;
  assign accept = in_valid && !in_stall;

  // A result that is not taken stays on offer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A write transaction yields its result on the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_WRITE |=> out_valid)
    else $error("write result missing");

  // A dilate transaction keeps the input side closed while it runs.
  a_dilate_busy: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_DILATE |=> in_stall)
    else $error("input accepted during dilation");

  // A valid read result never carries an invalid-pixel count.
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> still_invalid == 17'd0)
    else $error("read result carries a count");

endmodule

bind masked_image_hole_dilation mihd_checker u_mihd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .op            (op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .read_valid    (read_valid),
  .still_invalid (still_invalid)
);

[tb/sv/tb_masked_image_hole_dilation.sv]
module tb_masked_image_hole_dilation;
  import mihd_pkg::*;

  typedef struct {
    op_t         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
    logic        valid;
  } pixel_cmd_t;

  typedef struct {
    logic [15:0]        value;
    logic               valid;
    logic [COUNT_W-1:0] holes;
  } pixel_resp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = '0;
  logic [7:0]         pixel_x = '0;
  logic [7:0]         pixel_y = '0;
  logic [15:0]        pixel_value = '0;
  logic               pixel_valid = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        read_value;
  logic               read_valid;
  logic [COUNT_W-1:0] still_invalid;

  masked_image_hole_dilation DUT (.*);

  always #10 clk = ~clk;

  // Shadow of the image and of the registers.
  logic [16:0] image_px [65536];
  logic [16:0] next_px [65536];
  logic [7:0]  passes_reg = PASS_COUNT_RST;
  logic [15:0] fill_reg = FILL_VALUE_RST;
  logic [8:0]  width_reg = IMAGE_SIZE_RST;
  logic [8:0]  height_reg = IMAGE_SIZE_RST;

  pixel_cmd_t  pending_cmds[$];
  pixel_resp_t expected_resps[$];
  pixel_cmd_t  cur_cmd;
  int          errors = 0;
  int          n_accepted = 0;
  int          n_reads = 0;
  int          n_dilates = 0;
  int          n_results = 0;
  bit          calm = 0;

  function automatic int clamp_size(logic [8:0] s);
    if (s == 0) return 1;
    if (s > 256) return 256;
    return s;
  endfunction

  function automatic pixel_resp_t apply_cmd(pixel_cmd_t c);
    pixel_resp_t r;
    int w, h, idx, sum, cnt, holes;
    bit in_image;
    r = '{value: '0, valid: 1'b0, holes: '0};
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    in_image = (c.x < w) && (c.y < h);
    idx = c.y * 256 + c.x;
    case (c.op)
      OP_WRITE: if (in_image) image_px[idx] = {c.valid, c.value};
      OP_READ: begin
        if (in_image && image_px[idx][16]) begin
          r.value = image_px[idx][15:0];
          r.valid = 1'b1;
        end else begin
          r.value = fill_reg;
        end
      end
      OP_DILATE: begin
        for (int p = 0; p < passes_reg; p++) begin
          next_px = image_px;
          for (int yy = 0; yy < h; yy++)
            for (int xx = 0; xx < w; xx++) begin
              idx = yy * 256 + xx;
              if (!image_px[idx][16]) begin
                sum = 0;
                cnt = 0;
                if (xx + 1 < w && image_px[idx+1][16]) begin
                  sum += image_px[idx+1][15:0]; cnt++;
                end
                if (xx > 0 && image_px[idx-1][16]) begin
                  sum += image_px[idx-1][15:0]; cnt++;
                end
                if (yy + 1 < h && image_px[idx+256][16]) begin
                  sum += image_px[idx+256][15:0]; cnt++;
                end
                if (yy > 0 && image_px[idx-256][16]) begin
                  sum += image_px[idx-256][15:0]; cnt++;
                end
                if (cnt > 0) next_px[idx] = {1'b1, 16'(sum / cnt)};
              end
            end
          image_px = next_px;
        end
        holes = 0;
        for (int yy = 0; yy < h; yy++)
          for (int xx = 0; xx < w; xx++)
            if (!image_px[yy*256+xx][16]) holes++;
        r.holes = (holes > 131071) ? 17'h1FFFF : COUNT_W'(holes);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: a new transaction is offered only once the previous one has gone.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_resps.push_back(apply_cmd(cur_cmd));
        n_accepted++;
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 6);
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        op <= cur_cmd.op;
        pixel_x <= cur_cmd.x;
        pixel_y <= cur_cmd.y;
        pixel_value <= cur_cmd.value;
        pixel_valid <= cur_cmd.valid;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls in short bursts, plus one long hold-off mid run.
  int stall_left = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && n_accepted >= 60) begin
      long_hold_done = 1;
      stall_left = 120;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pixel_resp_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result transaction value=%h valid=%b holes=%0d",
                 $time, read_value, read_valid, still_invalid);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        if (read_value !== want.value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.value, read_value);
          errors++;
        end
        if (read_valid !== want.valid) begin
          $display("%0t: read_valid expected %b actual %b", $time, want.valid, read_valid);
          errors++;
        end
        if (still_invalid !== want.holes) begin
          $display("%0t: still_invalid expected %0d actual %0d",
                   $time, want.holes, still_invalid);
          errors++;
        end
      end
    end
  end

  task automatic add_cmd(op_t o, int x, int y, int v, bit vld);
    pending_cmds.push_back('{op: o, x: 8'(x), y: 8'(y), value: 16'(v), valid: vld});
  endtask

  task automatic program_regs(int passes, int fill, int w, int h);
    logic [15:0] vals [4];
    vals = '{16'(passes), 16'(fill), 16'(w), 16'(h)};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      case (cfg_index_t'(i))
        CFG_PASS_COUNT:   passes_reg = vals[i][7:0];
        CFG_FILL_VALUE:   fill_reg = vals[i];
        CFG_IMAGE_WIDTH:  width_reg = vals[i][8:0];
        CFG_IMAGE_HEIGHT: height_reg = vals[i][8:0];
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic fill_image(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        add_cmd(OP_WRITE, x, y, $urandom_range(0, 65535), $urandom_range(0, 9) < 3);
  endtask

  initial begin
    int w, h, sel, xs[$], ys[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full 256 x 256 image, corners and field extremes.
    add_cmd(OP_WRITE, 0, 0, 0, 1);
    add_cmd(OP_WRITE, 255, 255, 16'hFFFF, 1);
    add_cmd(OP_WRITE, 255, 0, 16'hA5A5, 0);
    add_cmd(OP_READ, 0, 0, 0, 0);
    add_cmd(OP_READ, 255, 255, 0, 0);
    add_cmd(OP_READ, 255, 0, 0, 0);
    add_cmd(OP_NONE, 255, 255, 16'hFFFF, 1);
    drain();

    // Zero-sized image saturates to one pixel; zero passes still report holes.
    program_regs(0, 16'hFFFF, 0, 0);
    add_cmd(OP_WRITE, 0, 0, 16'h1234, 0);
    add_cmd(OP_WRITE, 5, 5, 16'h4321, 1);
    add_cmd(OP_READ, 5, 5, 0, 0);
    add_cmd(OP_DILATE, 0, 0, 0, 0);
    add_cmd(OP_READ, 0, 0, 0, 0);
    drain();

    // Maximum pass count on a tiny image seeded from two valid pixels.
    program_regs(255, 16'h00FF, 3, 2);
    add_cmd(OP_WRITE, 0, 0, 16'hFFFF, 1);
    add_cmd(OP_WRITE, 1, 0, 0, 0);
    add_cmd(OP_WRITE, 2, 0, 0, 0);
    add_cmd(OP_WRITE, 0, 1, 0, 0);
    add_cmd(OP_WRITE, 1, 1, 16'h0001, 1);
    add_cmd(OP_WRITE, 2, 1, 0, 0);
    add_cmd(OP_DILATE, 0, 0, 0, 0);
    add_cmd(OP_READ, 2, 0, 0, 0);
    add_cmd(OP_READ, 2, 1, 0, 0);
    add_cmd(OP_READ, 3, 1, 0, 0);
    drain();

    // Oversized width saturates to the full row; scattered writes then read back.
    program_regs($urandom_range(0, 255), $urandom_range(0, 65535), 300, 256);
    for (int i = 0; i < 40; i++) begin
      xs.push_back($urandom_range(0, 255));
      ys.push_back($urandom_range(0, 255));
      add_cmd(OP_WRITE, xs[i], ys[i], $urandom_range(0, 65535), $urandom_range(0, 1));
    end
    for (int i = 0; i < 40; i++) add_cmd(OP_READ, xs[i], ys[i], 0, 0);
    drain();

    // Small images: whole image written first, then a random mix.
    for (int ph = 0; ph < 6; ph++) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if (ph == 5) calm = 1;
      program_regs($urandom_range(0, 6), $urandom_range(0, 65535), w, h);
      fill_image(w, h);
      for (int i = 0; i < 45; i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 6)
          add_cmd(OP_WRITE, $urandom_range(0, w), $urandom_range(0, h),
                  $urandom_range(0, 65535), $urandom_range(0, 3) == 0);
        else if (sel < 14)
          add_cmd(OP_READ, $urandom_range(0, w), $urandom_range(0, h), 0, 0);
        else if (sel < 15)
          add_cmd(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), 1);
        else if (sel < 19)
          add_cmd(OP_DILATE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
        else
          add_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
      end
      drain();
    end

    $display("Covered %0d transactions (%0d reads, %0d dilates, %0d results checked)",
             n_accepted, n_reads, n_dilates, n_results);
    $display("over saturated, single-pixel and small random image sizes.");
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk)
    if (in_valid && !in_stall) begin
      if (op == OP_READ) n_reads++;
      if (op == OP_DILATE) n_dilates++;
    end

  initial begin
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
